/* hw/rtl/apra_pkg.sv */
package apra_pkg;

	localparam int HISTORY_DEPTH = 5;
	localparam int COUNT_BITS    = 12;

	localparam int HIST_IDX_BITS = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int SUM_BITS      = COUNT_BITS + $clog2(HISTORY_DEPTH);

	localparam int LOCKOUT_W  = 16;
	localparam int WINDOW_W   = 24;
	localparam int OFFSET_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int MINSUM_W   = 15;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int SPEED_W    = 16;
	localparam int WCOUNT_W   = 12;
	localparam int CSUM_W     = 15;

	localparam int PRE_BITS  = SUM_BITS + 9;
	localparam int PROD_BITS = PRE_BITS + GAIN_W;
	localparam int CMP_W     = (SUM_BITS > MINSUM_W) ? SUM_BITS : MINSUM_W;
	localparam int FRAC_BITS = 16;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [PROD_BITS:0]    ROUND_HALF = (PROD_BITS + 1)'(1) << (FRAC_BITS - 1);

	localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST = LOCKOUT_W'(300);
	localparam logic [WINDOW_W-1:0]  WINDOW_RST  = WINDOW_W'(1000000);
	localparam logic [OFFSET_W-1:0]  OFFSET_RST  = OFFSET_W'(13889);
	localparam logic [GAIN_W-1:0]    GAIN_RST    = GAIN_W'(733);
	localparam logic [MINSUM_W-1:0]  MINSUM_RST  = MINSUM_W'(13);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOCKOUT = 3'd0,
		REG_WINDOW  = 3'd1,
		REG_OFFSET  = 3'd2,
		REG_GAIN    = 3'd3,
		REG_MINSUM  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [LOCKOUT_W-1:0] lockout_ticks;
		logic [WINDOW_W-1:0]  window_ticks;
		logic [OFFSET_W-1:0]  offset_q8;
		logic [GAIN_W-1:0]    gain_q16;
		logic [MINSUM_W-1:0]  min_sum;
	} cfg_t;

	typedef struct packed {
		logic                  fire;
		logic [COUNT_BITS-1:0] count;
		logic [SUM_BITS-1:0]   sum;
	} win_t;

	typedef struct packed {
		logic s2_valid;
		logic s3_valid;
	} pipe_stat_t;

endpackage

/* hw/rtl/apra_window.sv */
module apra_window (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tick,
	input  logic          edge_req,
	input  apra_pkg::cfg_t cfg,
	output apra_pkg::win_t win
);
	import apra_pkg::*;

	logic [LOCKOUT_W-1:0]  since_q;
	logic [WINDOW_W-1:0]   elapsed_q;
	logic [COUNT_BITS-1:0] pulse_q;
	logic [COUNT_BITS-1:0] hist_q [HISTORY_DEPTH];
	logic [SUM_BITS-1:0]   hist_sum_q;

	logic [LOCKOUT_W-1:0]  since_inc;
	logic                  counted;
	logic [COUNT_BITS-1:0] pulse_nxt;
	logic [WINDOW_W:0]     elapsed_inc;
	logic                  win_end;
	logic                  found;
	logic [HIST_IDX_BITS-1:0] fill_idx;

	assign since_inc   = (since_q == '1) ? since_q : since_q + 1'b1;
	assign counted     = edge_req && (since_inc >= cfg.lockout_ticks);
	assign pulse_nxt   = (counted && pulse_q != COUNT_MAX) ? pulse_q + 1'b1 : pulse_q;
	assign elapsed_inc = {1'b0, elapsed_q} + 1'b1;
	assign win_end     = elapsed_inc >= {1'b0, cfg.window_ticks};

	// first empty slot, lowest index wins
	always_comb begin
		found    = 1'b0;
		fill_idx = '0;
		for (int i = HISTORY_DEPTH - 1; i >= 0; i--) begin
			if (hist_q[i] == '0) begin
				found    = 1'b1;
				fill_idx = HIST_IDX_BITS'(i);
			end
		end
	end

	assign win.fire  = tick && win_end;
	assign win.count = pulse_nxt;
	assign win.sum   = found ? SUM_BITS'(pulse_nxt) * SUM_BITS'(HISTORY_DEPTH) : hist_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q    <= '1;
			elapsed_q  <= '0;
			pulse_q    <= '0;
			hist_sum_q <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else if (tick) begin
			since_q <= counted ? '0 : since_inc;
			if (win_end) begin
				elapsed_q <= '0;
				pulse_q   <= '0;
				if (found) begin
					hist_q[fill_idx] <= pulse_nxt;
					hist_sum_q       <= hist_sum_q + SUM_BITS'(pulse_nxt);
				end else begin
					for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
						hist_q[i] <= hist_q[i+1];
					end
					hist_q[HISTORY_DEPTH-1] <= pulse_nxt;
					hist_sum_q <= hist_sum_q - SUM_BITS'(hist_q[0]) + SUM_BITS'(pulse_nxt);
				end
			end else begin
				elapsed_q <= elapsed_inc[WINDOW_W-1:0];
				pulse_q   <= pulse_nxt;
			end
		end
	end

endmodule

/* hw/rtl/apra_speed.sv */
module apra_speed (
	input  logic                           clk,
	input  logic                           arst_n,
	input  apra_pkg::cfg_t                 cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [apra_pkg::COUNT_BITS-1:0] in_count,
	input  logic [apra_pkg::SUM_BITS-1:0]   in_sum,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [apra_pkg::SPEED_W-1:0]    out_speed,
	output logic [apra_pkg::COUNT_BITS-1:0] out_count,
	output logic [apra_pkg::SUM_BITS-1:0]   out_sum,
	output apra_pkg::pipe_stat_t           stat
);
	import apra_pkg::*;

	logic                  v_s2;
	logic [PROD_BITS-1:0]  prod_s2;
	logic                  below_s2;
	logic [COUNT_BITS-1:0] count_s2;
	logic [SUM_BITS-1:0]   sum_s2;

	logic                  v_s3;
	logic [SPEED_W-1:0]    speed_s3;
	logic [COUNT_BITS-1:0] count_s3;
	logic [SUM_BITS-1:0]   sum_s3;

	logic adv2;
	logic adv3;
	logic [PRE_BITS-1:0]            pre;
	logic [PROD_BITS-1:0]           prod;
	logic                           below;
	logic [PROD_BITS:0]             rnd;
	logic [PROD_BITS-FRAC_BITS:0]   shifted;
	logic                           sat;
	logic [SPEED_W-1:0]             speed;

	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign in_ready = adv2;

	assign pre   = (PRE_BITS'(in_sum) << 8) + PRE_BITS'(cfg.offset_q8);
	assign prod  = PROD_BITS'(pre) * PROD_BITS'(cfg.gain_q16);
	assign below = CMP_W'(in_sum) < CMP_W'(cfg.min_sum);

	// round half up, then clamp to the q8.8 range; zero when the sum is below min_sum
	assign rnd     = {1'b0, prod_s2} + ROUND_HALF;
	assign shifted = rnd[PROD_BITS:FRAC_BITS];
	assign sat     = |shifted[PROD_BITS-FRAC_BITS:SPEED_W];
	assign speed   = below_s2 ? '0 : (sat ? '1 : shifted[SPEED_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv2) begin
				v_s2 <= in_valid;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && in_valid) begin
			prod_s2  <= prod;
			below_s2 <= below;
			count_s2 <= in_count;
			sum_s2   <= in_sum;
		end
		if (adv3 && v_s2) begin
			speed_s3 <= speed;
			count_s3 <= count_s2;
			sum_s3   <= sum_s2;
		end
	end

	assign out_valid     = v_s3;
	assign out_speed     = speed_s3;
	assign out_count     = count_s3;
	assign out_sum       = sum_s3;
	assign stat.s2_valid = v_s2;
	assign stat.s3_valid = v_s3;

endmodule

/* hw/rtl/anemometer_pulse_rate_averager_unit.sv */
// channel   dir  handshake            beat fields
// in        in   in_valid/in_ready    edge_req
// out       out  out_valid/out_ready  speed_q8, window_count, count_sum
// cfg       in   cfg_wr_en            cfg_index, cfg_data
//
// one tick beat is taken per cycle while in_ready is high; the debounce and window counters update in that cycle
// a window-end beat passes the window, multiply and round registers, where a stall can hold it, before the output
// up to three results can be buffered before in_ready drops
// reset clears the counters and history; the tick counter since the last edge starts saturated
// cfg writes take effect on the next cycle
module anemometer_pulse_rate_averager_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                edge_req,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [apra_pkg::SPEED_W-1:0]        speed_q8,
	output logic [apra_pkg::WCOUNT_W-1:0]       window_count,
	output logic [apra_pkg::CSUM_W-1:0]         count_sum,
	input  logic                                cfg_wr_en,
	input  logic [apra_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [apra_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import apra_pkg::*;

	cfg_t       cfg_q;
	win_t       win;
	logic       v_s1;
	logic [COUNT_BITS-1:0] count_s1;
	logic [SUM_BITS-1:0]   sum_s1;
	logic       spd_ready;
	logic       adv1;
	logic       tick;
	pipe_stat_t stat;
	logic [SPEED_W-1:0]    spd_speed;
	logic [COUNT_BITS-1:0] spd_count;
	logic [SUM_BITS-1:0]   spd_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout_ticks <= LOCKOUT_RST;
			cfg_q.window_ticks  <= WINDOW_RST;
			cfg_q.offset_q8     <= OFFSET_RST;
			cfg_q.gain_q16      <= GAIN_RST;
			cfg_q.min_sum       <= MINSUM_RST;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LOCKOUT: cfg_q.lockout_ticks <= cfg_data[LOCKOUT_W-1:0];
				REG_WINDOW:  cfg_q.window_ticks  <= cfg_data[WINDOW_W-1:0];
				REG_OFFSET:  cfg_q.offset_q8     <= cfg_data[OFFSET_W-1:0];
				REG_GAIN:    cfg_q.gain_q16      <= cfg_data[GAIN_W-1:0];
				REG_MINSUM:  cfg_q.min_sum       <= cfg_data[MINSUM_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv1     = !v_s1 || spd_ready;
	assign in_ready = adv1;
	assign tick     = in_valid && in_ready;

	apra_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.edge_req (edge_req),
		.cfg      (cfg_q),
		.win      (win)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= win.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && win.fire) begin
			count_s1 <= win.count;
			sum_s1   <= win.sum;
		end
	end

	apra_speed u_speed (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (v_s1),
		.in_ready  (spd_ready),
		.in_count  (count_s1),
		.in_sum    (sum_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_speed (spd_speed),
		.out_count (spd_count),
		.out_sum   (spd_sum),
		.stat      (stat)
	);

	assign speed_q8     = spd_speed;
	assign window_count = WCOUNT_W'(spd_count);
	assign count_sum    = CSUM_W'(spd_sum);

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && stat.s2_valid && out_valid)
		else $error("input stalled with a free pipeline slot");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !spd_ready |=> v_s1 && $stable(count_s1) && $stable(sum_s1))
		else $error("stage one beat lost while stalled");

	a_below_cutoff_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (CMP_W'(spd_sum) < CMP_W'(cfg_q.min_sum)) |-> speed_q8 == '0)
		else $error("speed not zero below cutoff");

	a_s3_fed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(stat.s2_valid))
		else $error("output beat without a stage two beat");
`endif

endmodule

/* tb/sv/wind_speed_checker.sv */
module wind_speed_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            edge_req,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [apra_pkg::SPEED_W-1:0]    speed_q8,
	input  logic [apra_pkg::WCOUNT_W-1:0]   window_count,
	input  logic [apra_pkg::CSUM_W-1:0]     count_sum,
	input  logic                            cfg_wr_en,
	input  logic [apra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [apra_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              pending
);
	import apra_pkg::*;

	typedef struct packed {
		logic [SPEED_W-1:0]  speed;
		logic [WCOUNT_W-1:0] count;
		logic [CSUM_W-1:0]   total;
	} wind_result_t;

	logic [LOCKOUT_W-1:0]  lockout;
	logic [WINDOW_W-1:0]   window_len;
	logic [OFFSET_W-1:0]   offset;
	logic [GAIN_W-1:0]     gain;
	logic [MINSUM_W-1:0]   min_sum;
	logic [LOCKOUT_W-1:0]  since_edge;
	logic [WINDOW_W-1:0]   elapsed;
	logic [COUNT_BITS-1:0] pulses;
	logic [COUNT_BITS-1:0] slots [HISTORY_DEPTH];
	wind_result_t          expected_q [$];

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	function automatic logic [SPEED_W-1:0] speed_of(input int unsigned total);
		longint unsigned p;
		if (total < min_sum)
			return '0;
		p = ((longint'(total) << 8) + offset) * gain;
		p = (p + 64'd32768) >> 16;
		if (p > 64'hFFFF)
			return '1;
		return p[SPEED_W-1:0];
	endfunction

	task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		case (reg_idx_t'(idx))
			REG_LOCKOUT: lockout = d[LOCKOUT_W-1:0];
			REG_WINDOW:  window_len = d[WINDOW_W-1:0];
			REG_OFFSET:  offset = d[OFFSET_W-1:0];
			REG_GAIN:    gain = d[GAIN_W-1:0];
			REG_MINSUM:  min_sum = d[MINSUM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic advance_tick(input logic pulse);
		logic [LOCKOUT_W:0]    se;
		logic [WINDOW_W:0]     el;
		logic [COUNT_BITS-1:0] cnt;
		int unsigned           total;
		bit                    filled;
		se = {1'b0, since_edge} + 1'b1;
		if (se[LOCKOUT_W])
			se = {1'b0, {LOCKOUT_W{1'b1}}};
		if (pulse && se >= lockout) begin
			if (pulses != COUNT_MAX)
				pulses++;
			since_edge = '0;
		end else begin
			since_edge = se[LOCKOUT_W-1:0];
		end
		el = {1'b0, elapsed} + 1'b1;
		if (el < window_len) begin
			elapsed = el[WINDOW_W-1:0];
			return;
		end
		elapsed = '0;
		cnt = pulses;
		pulses = '0;
		filled = 1'b0;
		total = 0;
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			if (!filled && slots[i] == '0) begin
				slots[i] = cnt;
				total = cnt * HISTORY_DEPTH;
				filled = 1'b1;
			end
		end
		if (!filled) begin
			for (int i = 0; i < HISTORY_DEPTH; i++)
				total += slots[i];
			for (int i = 0; i < HISTORY_DEPTH - 1; i++)
				slots[i] = slots[i+1];
			slots[HISTORY_DEPTH-1] = cnt;
		end
		expected_q.push_back('{speed_of(total), cnt, CSUM_W'(total)});
	endtask

	task automatic check_beat();
		wind_result_t want;
		if (expected_q.size() == 0) begin
			flag_mismatch("result beat with nothing expected, speed_q8", speed_q8, 0);
			return;
		end
		want = expected_q.pop_front();
		if (speed_q8 !== want.speed)
			flag_mismatch("speed_q8", speed_q8, want.speed);
		if (window_count !== want.count)
			flag_mismatch("window_count", window_count, want.count);
		if (count_sum !== want.total)
			flag_mismatch("count_sum", count_sum, want.total);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout = LOCKOUT_RST;
			window_len = WINDOW_RST;
			offset = OFFSET_RST;
			gain = GAIN_RST;
			min_sum = MINSUM_RST;
			since_edge = '1;
			elapsed = '0;
			pulses = '0;
			foreach (slots[i])
				slots[i] = '0;
			expected_q.delete();
			mismatches = 0;
		end else begin
			// a tick on the write edge still sees the old settings
			if (in_valid && in_ready)
				advance_tick(edge_req);
			if (cfg_wr_en)
				apply_write(cfg_index, cfg_data);
			if (out_valid && out_ready)
				check_beat();
		end
		pending = expected_q.size();
	end

endmodule

/* tb/sv/tb_anemometer_pulse_rate_averager_unit.sv */
module tb_anemometer_pulse_rate_averager_unit;
	import apra_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  edge_req;
	logic                  out_valid;
	logic                  out_ready;
	logic [SPEED_W-1:0]    speed_q8;
	logic [WCOUNT_W-1:0]   window_count;
	logic [CSUM_W-1:0]     count_sum;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    pending;
	int unsigned           gap_pct;
	int unsigned           stall_pct;
	int unsigned           cycle_count;

	anemometer_pulse_rate_averager_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .edge_req(edge_req),
		.out_valid(out_valid), .out_ready(out_ready),
		.speed_q8(speed_q8), .window_count(window_count), .count_sum(count_sum),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	wind_speed_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .edge_req(edge_req),
		.out_valid(out_valid), .out_ready(out_ready),
		.speed_q8(speed_q8), .window_count(window_count), .count_sum(count_sum),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic int unsigned skewed(input int unsigned lo, input int unsigned hi);
		case ($urandom_range(9))
			0: return lo;
			1: return hi;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_tick(input logic pulse);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		edge_req <= pulse;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_ticks(input int n, input int unsigned edge_pct);
		for (int i = 0; i < n; i++)
			send_tick($urandom_range(99) < edge_pct);
	endtask

	// let every outstanding window result drain, then idle for the pipeline
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic program_random_setting();
		case ($urandom_range(4))
			0, 1, 2: cfg_write(REG_LOCKOUT, $urandom_range(6));
			3:       cfg_write(REG_LOCKOUT, $urandom_range(40));
			default: cfg_write(REG_LOCKOUT, skewed(0, 65535));
		endcase
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: cfg_write(REG_WINDOW, $urandom_range(12));
			6, 7, 8:          cfg_write(REG_WINDOW, $urandom_range(60));
			default:          cfg_write(REG_WINDOW, $urandom_range(300));
		endcase
		cfg_write(REG_OFFSET, skewed(0, 65535));
		cfg_write(REG_GAIN, skewed(0, 65535));
		if ($urandom_range(3) == 0)
			cfg_write(REG_MINSUM, skewed(0, 20475));
		else
			cfg_write(REG_MINSUM, $urandom_range(80));
		if ($urandom_range(3) == 0)
			cfg_write(CFG_IDX_W'(REG_MINSUM) + CFG_IDX_W'($urandom_range(3, 1)),
				$urandom_range(32'hFFFFFF));
	endtask

	initial begin
		logic [7:0]  pattern;
		int unsigned edge_pct;
		arst_n = 1'b0;
		in_valid = 1'b0;
		edge_req = 1'b0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycle_count = 0;
		gap_pct = 9;
		stall_pct = 62;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one window per tick, lockout off, history fill and empty slots
		cfg_write(REG_LOCKOUT, 0);
		cfg_write(REG_WINDOW, 1);
		cfg_write(REG_OFFSET, 0);
		cfg_write(REG_GAIN, 65535);
		cfg_write(REG_MINSUM, 0);
		for (int k = 1; k <= 3; k++)
			cfg_write(CFG_IDX_W'(REG_MINSUM) + CFG_IDX_W'(k), 32'hFFFFFF);
		pattern = 8'b0110_1110;
		for (int i = 0; i < 8; i++)
			send_tick(pattern[i]);

		// debounce against continuous edges
		drain();
		cfg_write(REG_LOCKOUT, 3);
		cfg_write(REG_WINDOW, 4);
		send_ticks(12, 100);

		// zero window length acts as one tick
		drain();
		cfg_write(REG_WINDOW, 0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);

		// register extremes
		drain();
		cfg_write(REG_LOCKOUT, 65535);
		cfg_write(REG_WINDOW, 16777215);
		cfg_write(REG_OFFSET, 65535);
		cfg_write(REG_GAIN, 0);
		cfg_write(REG_MINSUM, 20475);
		send_ticks(4, 100);
		drain();
		cfg_write(REG_WINDOW, 2);
		send_ticks(2, 100);

		for (int phase = 0; phase < 3; phase++) begin
			drain();
			case (phase)
				0: begin
					gap_pct = 9;
					stall_pct = 62;
				end
				1: begin
					gap_pct = 62;
					stall_pct = 9;
				end
				default: begin
					gap_pct = 0;
					stall_pct = 0;
				end
			endcase
			for (int sub = 0; sub < 4; sub++) begin
				drain();
				program_random_setting();
				case ($urandom_range(5))
					0:       edge_pct = 0;
					1:       edge_pct = 100;
					default: edge_pct = $urandom_range(100);
				endcase
				send_ticks(100, edge_pct);
			end
		end

		drain();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/apra_pkg.sv
hw/rtl/apra_window.sv
hw/rtl/apra_speed.sv
hw/rtl/anemometer_pulse_rate_averager_unit.sv
tb/sv/wind_speed_checker.sv
tb/sv/tb_anemometer_pulse_rate_averager_unit.sv
